[rtl/core/page_upload_deframer_top_assert.svh]
// assertion macros for the port checker in pud_checker.sv
// expects clk and rst in the scope where a macro is used
`ifndef PAGE_UPLOAD_DEFRAMER_TOP_ASSERT_SVH
`define PAGE_UPLOAD_DEFRAMER_TOP_ASSERT_SVH

// checked outside reset
`define PUD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pud assertion failed");

// checked during reset as well
`define PUD_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pud reset assertion failed");

`endif

[rtl/core/pud_pkg.sv]
// shared types and constants for the page upload deframer
// no dependencies
package pud_pkg;

  localparam int HEADER_LEN = 8;
  localparam int HDR_CNT_W  = 3;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_LEN - 1);
  localparam int NEED_W     = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_OPEN  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_INACTIVE = 2'd1;
  localparam logic [1:0] ERR_HEADER   = 2'd2;
  localparam logic [1:0] ERR_TOOBIG   = 2'd3;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_W     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_H     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  error_code;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        page_start;
    logic [15:0] page_width;
    logic [15:0] page_height;
    logic [15:0] header_reserved;
    logic        page_done;
    logic [15:0] page_index;
    logic [15:0] pages_received;
  } out_t;

  typedef struct packed {
    logic [7:0]  magic_value;
    logic [7:0]  version_value;
    logic [15:0] max_width;
    logic [15:0] max_height;
    logic [31:0] page_size_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  magic;
    logic [7:0]  version;
    logic [15:0] width;
    logic [15:0] height;
  } hdr_fields_t;

  typedef struct packed {
    logic [1:0]        code;
    logic [NEED_W-1:0] need;
  } hdr_result_t;

endpackage

[rtl/core/pud_header_check.sv]
// header validation and body length for the page upload deframer
// depends on pud_pkg; body length is registered from the stored header bytes
module pud_header_check (
  input  logic                 clk,
  input  pud_pkg::hdr_fields_t hdr,
  input  pud_pkg::cfg_t        cfg,
  output pud_pkg::hdr_result_t result
);
  import pud_pkg::*;

  logic [13:0]       row_bytes;
  logic [29:0]       need_full;
  logic [NEED_W-1:0] need;
  logic [31:0]       total;

  assign row_bytes = 14'((17'(hdr.width) + 17'd7) >> 3);
  assign need_full = 30'(row_bytes) * 30'(hdr.height);

  // width and height bytes settle at least two transactions before the last header byte
  always_ff @(posedge clk) begin
    need <= need_full[NEED_W-1:0];
  end

  assign total = 32'(need) + 32'(HEADER_LEN);

  always_comb begin
    result.need = need;
    if (hdr.magic != cfg.magic_value || hdr.version != cfg.version_value) begin
      result.code = ERR_HEADER;
    end else if (hdr.width == 16'd0 || hdr.height == 16'd0 ||
                 hdr.width > cfg.max_width || hdr.height > cfg.max_height) begin
      result.code = ERR_HEADER;
    end else if (total > cfg.page_size_limit) begin
      result.code = ERR_TOOBIG;
    end else begin
      result.code = ERR_NONE;
    end
  end

endmodule

[rtl/core/page_upload_deframer_top.sv]
// page upload deframer top level: session control, header capture, body forwarding
// depends on pud_pkg and pud_header_check
//
// channel  dir  handshake                payload
// in       in   in_valid / in_ready      in_item  (pud_pkg::in_t)
// out      out  out_valid / out_ready    out_item (pud_pkg::out_t)
// cfg      in   cfg_we                   cfg_index, cfg_data
//
// one transaction per cycle while results are taken; each result is registered and appears in the cycle after its input
// the result register decides the rate: in_ready is low only while a result is held
// synchronous reset clears session state and loads register defaults
// a stalled output holds its result and blocks further input until taken
module page_upload_deframer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pud_pkg::in_t                   in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pud_pkg::out_t                  out_item,
  input  logic                           cfg_we,
  input  logic [pud_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pud_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pud_pkg::*;

  cfg_t              cfg;
  logic [1:0]        phase, phase_next;
  logic [HDR_CNT_W-1:0] hcount, hcount_next;
  logic [NEED_W-1:0] body_need, body_need_next;
  logic [NEED_W-1:0] body_count, body_count_next;
  logic [NEED_W-1:0] body_count_inc;
  logic [15:0]       page_counter, page_counter_next;
  logic [1:0]        sticky, sticky_next;
  logic [7:0]        hdr_store [0:HEADER_LEN-2];
  logic              accept;
  logic              hdr_write;
  out_t              res;
  hdr_fields_t       hdr;
  hdr_result_t       hdr_res;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_value     <= 8'd80;
      cfg.version_value   <= 8'd1;
      cfg.max_width       <= 16'd2048;
      cfg.max_height      <= 16'd2048;
      cfg.page_size_limit <= 32'd524288;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAGIC:     cfg.magic_value     <= cfg_data[7:0];
        CFG_VERSION:   cfg.version_value   <= cfg_data[7:0];
        CFG_MAX_W:     cfg.max_width       <= cfg_data[15:0];
        CFG_MAX_H:     cfg.max_height      <= cfg_data[15:0];
        CFG_MAX_BYTES: cfg.page_size_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign hdr.magic   = hdr_store[0];
  assign hdr.version = hdr_store[1];
  assign hdr.width   = {hdr_store[3], hdr_store[2]};
  assign hdr.height  = {hdr_store[5], hdr_store[4]};

  pud_header_check u_check (
    .clk    (clk),
    .hdr    (hdr),
    .cfg    (cfg),
    .result (hdr_res)
  );

  assign hdr_write = accept && in_item.op == OP_DATA && phase == PH_HEADER &&
                     hcount != HDR_LAST;

  // last header byte is used live and never stored
  always_ff @(posedge clk) begin
    if (hdr_write) begin
      hdr_store[hcount] <= in_item.data_byte;
    end
  end

  assign body_count_inc = body_count + NEED_W'(1);

  always_comb begin
    res               = '0;
    phase_next        = phase;
    hcount_next       = hcount;
    body_need_next    = body_need;
    body_count_next   = body_count;
    page_counter_next = page_counter;
    sticky_next       = sticky;
    unique case (in_item.op)
      OP_OPEN: begin
        if (phase != PH_IDLE) begin
          sticky_next    = ERR_INACTIVE;
          res.error_code = ERR_INACTIVE;
        end else begin
          phase_next        = PH_HEADER;
          hcount_next       = '0;
          body_need_next    = '0;
          body_count_next   = '0;
          page_counter_next = '0;
          sticky_next       = ERR_NONE;
          res.ok            = 1'b1;
        end
      end
      OP_CLOSE: begin
        res.pages_received = page_counter;
        phase_next         = PH_IDLE;
        res.ok             = (sticky == ERR_NONE);
        res.error_code     = sticky;
      end
      OP_DATA: begin
        unique case (phase)
          PH_HEADER: begin
            res.page_index = page_counter;
            if (hcount == HDR_LAST) begin
              hcount_next = '0;
              if (hdr_res.code != ERR_NONE) begin
                sticky_next    = hdr_res.code;
                phase_next     = PH_IDLE;
                res.error_code = hdr_res.code;
              end else begin
                body_need_next      = hdr_res.need;
                body_count_next     = '0;
                phase_next          = PH_BODY;
                res.ok              = 1'b1;
                res.page_start      = 1'b1;
                res.page_width      = hdr.width;
                res.page_height     = hdr.height;
                res.header_reserved = {in_item.data_byte, hdr_store[HEADER_LEN-2]};
              end
            end else begin
              hcount_next = hcount + HDR_CNT_W'(1);
              res.ok      = 1'b1;
            end
          end
          PH_BODY: begin
            res.ok         = 1'b1;
            res.body_valid = 1'b1;
            res.body_byte  = in_item.data_byte;
            res.page_index = page_counter;
            if (body_count_inc == body_need) begin
              res.page_done     = 1'b1;
              page_counter_next = page_counter + 16'd1;
              phase_next        = PH_HEADER;
              hcount_next       = '0;
              body_count_next   = '0;
              body_need_next    = '0;
            end else begin
              body_count_next = body_count_inc;
            end
          end
          default: begin
            sticky_next    = ERR_INACTIVE;
            res.error_code = ERR_INACTIVE;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hcount       <= '0;
      body_need    <= '0;
      body_count   <= '0;
      page_counter <= '0;
      sticky       <= ERR_NONE;
    end else if (accept) begin
      phase        <= phase_next;
      hcount       <= hcount_next;
      body_need    <= body_need_next;
      body_count   <= body_count_next;
      page_counter <= page_counter_next;
      sticky       <= sticky_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= res;
    end
  end

endmodule

[rtl/core/pud_checker.sv]
// port-level checks for the page upload deframer, bound to the top level
// depends on pud_pkg and page_upload_deframer_top_assert.svh
`include "page_upload_deframer_top_assert.svh"

module pud_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input pud_pkg::out_t out_item
);
  import pud_pkg::*;

  // held result keeps its value
  `PUD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item))
  // input side is never blocked by an empty result register
  `PUD_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)
  // a success carries no error code
  `PUD_ASSERT(a_ok_no_error, out_valid && out_item.ok |-> out_item.error_code == ERR_NONE)
  // forwarded body bytes and header starts are always successes
  `PUD_ASSERT(a_body_ok, out_valid && (out_item.body_valid || out_item.page_start) |-> out_item.ok)
  // no transaction shown right after reset
  `PUD_ASSERT_RST(a_reset_empty, rst |=> !out_valid)

endmodule

bind page_upload_deframer_top pud_checker u_pud_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

[tb/page_upload_deframer_checker.sv]
// checker for the page upload deframer: watches the input, output and register ports,
// predicts each result from the input transactions and compares them field by field
// depends on pud_pkg
module page_upload_deframer_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  pud_pkg::in_t                   in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  pud_pkg::out_t                  out_item,
  input  logic                           cfg_we,
  input  logic [pud_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pud_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             outstanding,
  output int                             compared,
  output int                             pages_done,
  output int                             headers_rejected
);
  import pud_pkg::*;

  localparam cfg_t CFG_RESET = '{8'd80, 8'd1, 16'd2048, 16'd2048, 32'd524288};

  cfg_t              cfg;
  logic [1:0]        phase;
  logic [7:0]        hdr_bytes [HEADER_LEN];
  logic [3:0]        hdr_cnt;
  logic [NEED_W-1:0] body_need;
  logic [NEED_W-1:0] body_cnt;
  logic [15:0]       page_cnt;
  logic [1:0]        sticky;
  out_t              awaited [$];

  task automatic report(input string what);
    fail_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic out_t deframe(input in_t item);
    out_t        r;
    logic [15:0] w, h, rsv;
    logic [1:0]  code;
    logic [63:0] need;
    r = '0;
    case (item.op)
      OP_OPEN: begin
        if (phase != PH_IDLE) begin
          sticky = ERR_INACTIVE;
          r.error_code = ERR_INACTIVE;
        end else begin
          phase = PH_HEADER;
          hdr_cnt = '0;
          body_need = '0;
          body_cnt = '0;
          page_cnt = '0;
          sticky = ERR_NONE;
          r.ok = 1'b1;
        end
      end
      OP_CLOSE: begin
        r.pages_received = page_cnt;
        phase = PH_IDLE;
        r.ok = (sticky == ERR_NONE);
        r.error_code = sticky;
      end
      OP_DATA: begin
        if (phase == PH_IDLE) begin
          sticky = ERR_INACTIVE;
          r.error_code = ERR_INACTIVE;
        end else if (phase == PH_HEADER) begin
          r.page_index = page_cnt;
          hdr_bytes[hdr_cnt[2:0]] = item.data_byte;
          hdr_cnt = hdr_cnt + 4'd1;
          if (hdr_cnt >= HEADER_LEN) begin
            w = {hdr_bytes[3], hdr_bytes[2]};
            h = {hdr_bytes[5], hdr_bytes[4]};
            rsv = {hdr_bytes[7], hdr_bytes[6]};
            code = ERR_NONE;
            need = '0;
            if (hdr_bytes[0] != cfg.magic_value || hdr_bytes[1] != cfg.version_value) begin
              code = ERR_HEADER;
            end else if (w == 0 || h == 0 || w > cfg.max_width || h > cfg.max_height) begin
              code = ERR_HEADER;
            end else begin
              need = ((64'(w) + 64'd7) >> 3) * 64'(h);
              if (64'd8 + need > 64'(cfg.page_size_limit)) code = ERR_TOOBIG;
            end
            if (code != ERR_NONE) begin
              sticky = code;
              phase = PH_IDLE;
              r.error_code = code;
              headers_rejected++;
            end else begin
              body_need = need[NEED_W-1:0];
              body_cnt = '0;
              phase = PH_BODY;
              r.ok = 1'b1;
              r.page_start = 1'b1;
              r.page_width = w;
              r.page_height = h;
              r.header_reserved = rsv;
            end
          end else begin
            r.ok = 1'b1;
          end
        end else begin
          r.ok = 1'b1;
          r.body_valid = 1'b1;
          r.body_byte = item.data_byte;
          r.page_index = page_cnt;
          body_cnt = body_cnt + 1'b1;
          if (body_cnt == body_need) begin
            r.page_done = 1'b1;
            page_cnt = page_cnt + 16'd1;
            phase = PH_HEADER;
            hdr_cnt = '0;
            body_cnt = '0;
            body_need = '0;
            pages_done++;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_result(input out_t got, input out_t want);
    check_field("ok", 32'(got.ok), 32'(want.ok));
    check_field("error_code", 32'(got.error_code), 32'(want.error_code));
    check_field("body_valid", 32'(got.body_valid), 32'(want.body_valid));
    check_field("body_byte", 32'(got.body_byte), 32'(want.body_byte));
    check_field("page_start", 32'(got.page_start), 32'(want.page_start));
    check_field("page_width", 32'(got.page_width), 32'(want.page_width));
    check_field("page_height", 32'(got.page_height), 32'(want.page_height));
    check_field("header_reserved", 32'(got.header_reserved), 32'(want.header_reserved));
    check_field("page_done", 32'(got.page_done), 32'(want.page_done));
    check_field("page_index", 32'(got.page_index), 32'(want.page_index));
    check_field("pages_received", 32'(got.pages_received), 32'(want.pages_received));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = CFG_RESET;
      phase = PH_IDLE;
      hdr_bytes = '{default: '0};
      hdr_cnt = '0;
      body_need = '0;
      body_cnt = '0;
      page_cnt = '0;
      sticky = ERR_NONE;
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          report("result transaction with nothing awaited");
        end else begin
          compare_result(out_item, awaited.pop_front());
          compared++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAGIC:     cfg.magic_value = cfg_data[7:0];
          CFG_VERSION:   cfg.version_value = cfg_data[7:0];
          CFG_MAX_W:     cfg.max_width = cfg_data[15:0];
          CFG_MAX_H:     cfg.max_height = cfg_data[15:0];
          CFG_MAX_BYTES: cfg.page_size_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) awaited.push_back(deframe(in_item));
    end
    outstanding = awaited.size();
  end

endmodule

[tb/page_upload_deframer_top_tb.sv]
// testbench top for the page upload deframer: clock, reset, register setup and
// session stimulus under varying idle patterns; checking is done by the checker module
// depends on pud_pkg, page_upload_deframer_top and page_upload_deframer_checker
module page_upload_deframer_top_tb;
  import pud_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 80;
  localparam int BODY_CAP = 48;

  localparam int PAGE_NEXT     = 0;
  localparam int PAGE_CUT      = 1;
  localparam int PAGE_REJECTED = 2;
  localparam int PAGE_CLOSED   = 3;

  localparam cfg_t CFG_HIGH  = '{8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF};
  localparam cfg_t CFG_LOW   = '{8'hFF, 8'h00, 16'd1, 16'd1, 32'd0};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count, outstanding, compared, pages_done, headers_rejected;

  cfg_t live_cfg = '{8'd80, 8'd1, 16'd2048, 16'd2048, 32'd524288};
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_asks = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   items_sent = 0;
  int   stall_cycles = 0;
  int   quiet_cycles = 0;

  always #5 clk = ~clk;

  page_upload_deframer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  page_upload_deframer_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .compared         (compared),
    .pages_done       (pages_done),
    .headers_rejected (headers_rejected)
  );

  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready) stall_cycles++;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{op: op, data_byte: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    put_reg(CFG_MAGIC, 32'(c.magic_value));
    put_reg(CFG_VERSION, 32'(c.version_value));
    put_reg(CFG_MAX_W, 32'(c.max_width));
    put_reg(CFG_MAX_H, 32'(c.max_height));
    put_reg(CFG_MAX_BYTES, c.page_size_limit);
    cfg_we <= 1'b0;
    live_cfg = c;
  endtask

  task automatic run_page(output int status);
    logic [7:0]      hb [HEADER_LEN];
    logic [7:0]      mg, vr;
    logic [15:0]     w, h;
    longint unsigned need;
    int              wcap, hcap, n, total, cut, k;
    bit              good, partial;
    wcap = (live_cfg.max_width < 40) ? int'(live_cfg.max_width) : 40;
    hcap = (live_cfg.max_height < 6) ? int'(live_cfg.max_height) : 6;
    mg = live_cfg.magic_value;
    vr = live_cfg.version_value;
    w = 16'($urandom_range(1, wcap));
    h = 16'($urandom_range(1, hcap));
    case ($urandom_range(0, 11))
      0: mg = mg ^ 8'($urandom_range(1, 255));
      1: vr = vr ^ 8'($urandom_range(1, 255));
      2: w = '0;
      3: h = '0;
      4: w = 16'($urandom_range(65535, live_cfg.max_width));
      5: h = 16'($urandom_range(65535, live_cfg.max_height));
      default: ;
    endcase
    need = ((64'(w) + 64'd7) >> 3) * 64'(h);
    good = (mg == live_cfg.magic_value) && (vr == live_cfg.version_value) &&
           (w != 0) && (h != 0) && (w <= live_cfg.max_width) &&
           (h <= live_cfg.max_height) && (64'd8 + need <= 64'(live_cfg.page_size_limit));
    partial = good && (need > BODY_CAP);
    n = !good ? 0 : (partial ? $urandom_range(1, BODY_CAP) : int'(need));
    hb[0] = mg;
    hb[1] = vr;
    hb[2] = w[7:0];
    hb[3] = w[15:8];
    hb[4] = h[7:0];
    hb[5] = h[15:8];
    hb[6] = 8'($urandom_range(255));
    hb[7] = 8'($urandom_range(255));
    total = HEADER_LEN + n;
    cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, total - 1) : -1;
    for (k = 0; k < total; k++) begin
      if (k == cut) begin
        // session closed in the middle of a page
        send(OP_CLOSE, 8'($urandom_range(255)));
        status = PAGE_CLOSED;
        return;
      end
      if ($urandom_range(0, 49) == 0) send(OP_UNUSED, 8'($urandom_range(255)));
      if ($urandom_range(0, 79) == 0) send(OP_OPEN, 8'($urandom_range(255)));
      send(OP_DATA, (k < HEADER_LEN) ? hb[k] : 8'($urandom_range(255)));
    end
    status = !good ? PAGE_REJECTED : (partial ? PAGE_CUT : PAGE_NEXT);
  endtask

  task automatic run_session();
    int pages, k, st;
    send(OP_OPEN, 8'($urandom_range(255)));
    pages = $urandom_range(1, 4);
    st = PAGE_NEXT;
    for (k = 0; k < pages && st == PAGE_NEXT; k++) run_page(st);
    if (st == PAGE_REJECTED && $urandom_range(0, 4) == 0) begin
      send(OP_DATA, 8'($urandom_range(255)));
    end else if (st != PAGE_CLOSED) begin
      send(OP_CLOSE, 8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input cfg_t c, input int n, input bit squeeze);
    int goal;
    bit paused;
    wait_drained();
    load_config(c);
    if (squeeze) hold_asks <= hold_asks + 1;
    goal = items_sent + n;
    paused = 0;
    while (items_sent < goal) begin
      run_session();
      if (!paused && items_sent >= goal - n / 2) begin
        wait_drained();
        paused = 1;
      end
    end
  endtask

  initial begin
    cfg_t mixed, tight, roomy;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle commands, duplicate open, smallest page, oversize page
    send(OP_CLOSE, 8'h00);
    send(OP_UNUSED, 8'hFF);
    send(OP_DATA, 8'h00);
    send(OP_CLOSE, 8'hFF);
    send(OP_OPEN, 8'h00);
    send(OP_OPEN, 8'hFF);
    send(OP_DATA, 8'h50);
    send(OP_DATA, 8'h01);
    send(OP_DATA, 8'h01);
    send(OP_DATA, 8'h00);
    send(OP_DATA, 8'h01);
    send(OP_DATA, 8'h00);
    send(OP_DATA, 8'hFF);
    send(OP_DATA, 8'hFF);
    send(OP_DATA, 8'hFF);
    send(OP_CLOSE, 8'h00);
    send(OP_OPEN, 8'h00);
    send(OP_DATA, 8'h50);
    send(OP_DATA, 8'h01);
    send(OP_DATA, 8'h00);
    send(OP_DATA, 8'h08);
    send(OP_DATA, 8'h00);
    send(OP_DATA, 8'h08);
    send(OP_DATA, 8'h00);
    send(OP_DATA, 8'h00);
    send(OP_CLOSE, 8'h00);

    mixed = '{8'($urandom_range(255)), 8'($urandom_range(255)), 16'd24, 16'd4, 32'd20};
    tight = '{8'($urandom_range(255)), 8'($urandom_range(255)), 16'd8, 16'd1, 32'd9};
    roomy = '{8'($urandom_range(255)), 8'($urandom_range(255)), 16'd40, 16'd6, 32'd38};

    send_idle_pct = 24;
    recv_idle_pct = 73;
    run_phase(CFG_HIGH, 120, 1'b0);
    run_phase(CFG_LOW, 120, 1'b0);
    send_idle_pct = 73;
    recv_idle_pct = 24;
    run_phase(mixed, 120, 1'b0);
    run_phase(tight, 120, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(roomy, 120, 1'b1);

    wait_drained();
    repeat (8) @(negedge clk);
    $display("covered %0d input transactions, %0d results compared, %0d input stall cycles",
             items_sent, compared, stall_cycles);
    $display("%0d pages completed, %0d headers rejected, six register settings",
             pages_done, headers_rejected);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[page_upload_deframer_top.f]
+incdir+rtl/core
rtl/core/pud_pkg.sv
rtl/core/pud_header_check.sv
rtl/core/page_upload_deframer_top.sv
rtl/core/pud_checker.sv
tb/page_upload_deframer_checker.sv
tb/page_upload_deframer_top_tb.sv
